### rtl/cta_pkg.sv
// ----------------------------------------------------------------------------
// cta_pkg
// Types and codes shared by the cursor table with owner quota and age limit.
// ----------------------------------------------------------------------------
`default_nettype none

package cta_pkg;

    localparam int KEY_W   = 64;
    localparam int STORE_W = 16;
    localparam int POS_W   = 64;
    localparam int OWNER_W = 32;
    localparam int STAMP_W = 48;
    localparam int CNT7_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EXPIRED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 2'd2;

    localparam logic [CNT7_W-1:0]  CAPACITY_RST = 7'd64;
    localparam logic [CNT7_W-1:0]  QUOTA_RST    = 7'd16;
    localparam logic [STAMP_W-1:0] MAX_AGE_RST  = 48'd86400000000;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STORE_W-1:0] store;
        logic [POS_W-1:0]   pos;
        logic [OWNER_W-1:0] owner;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,
        S_EVICT,
        S_STAMP,
        S_WRITE,
        S_GSCAN,
        S_GAGE,
        S_GCHK,
        S_PURGE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/cursor_table_quota_age_eviction.sv
// Add: a count scan, an eviction step, a stamp scan that restarts on each stamp bump, then the write.
// Get: a key scan, then an age check, plus a purge scan when the entry has expired.
// One request at a time; all table scans go one entry per cycle over one RAM read port.
// Result sits in an output register, so the next request may start while it waits.
// Synchronous active-low reset clears valid bits, config to defaults; table RAM uncleared.
// ----------------------------------------------------------------------------
// cursor_table_quota_age_eviction
// Cursor table with per-owner quota, global capacity and age-based purge.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_table_quota_age_eviction #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_operation,
    input  wire logic [cta_pkg::KEY_W-1:0]       i_cursor_key,
    input  wire logic [cta_pkg::STORE_W-1:0]     i_store_id,
    input  wire logic [cta_pkg::POS_W-1:0]       i_resume_position,
    input  wire logic [cta_pkg::OWNER_W-1:0]     i_owner_session,
    input  wire logic [cta_pkg::STAMP_W-1:0]     i_now_ticks,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [1:0]                           o_status,
    output logic [cta_pkg::STORE_W-1:0]          o_found_store_id,
    output logic [cta_pkg::POS_W-1:0]            o_found_position,
    output logic [cta_pkg::OWNER_W-1:0]          o_found_session,
    output logic [cta_pkg::STAMP_W-1:0]          o_found_stamp,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cta_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cta_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cta_pkg::*;

    localparam int N  = TABLE_ENTRIES;
    localparam int IW = $clog2(N);
    localparam int AW = $clog2(N + 1);
    localparam int CW = (AW > CNT7_W) ? AW : CNT7_W;

    t_state r_state, n_state;

    logic [CNT7_W-1:0]  r_capacity, r_quota;
    logic [STAMP_W-1:0] r_max_age;

    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [STORE_W-1:0] r_store;
    logic [POS_W-1:0]   r_pos;
    logic [OWNER_W-1:0] r_owner;
    logic [STAMP_W-1:0] r_now;

    t_entry             r_mem [N];
    t_entry             r_rd;
    logic [N-1:0]       r_valid;

    logic [AW-1:0]      r_aidx;
    logic               r_pv;
    logic [IW-1:0]      r_pidx;

    logic [AW-1:0]      r_own_cnt, r_total;
    logic               r_has1, r_has2, r_has_oth, r_match_ok;
    logic [STAMP_W-1:0] r_min1, r_min2, r_min_oth;
    logic [IW-1:0]      r_slot1, r_slot2, r_slot_oth, r_match;

    logic [STAMP_W-1:0] r_cand;
    logic               r_free_found;
    logic [IW-1:0]      r_free;

    logic [STAMP_W-1:0] r_age, r_limit;
    logic [1:0]         r_status;
    t_entry             r_found;

    logic               w_accept, w_load, w_scan, w_end, w_restart;
    logic               w_ev, w_own, w_keyhit, w_stamphit;
    logic               w_own_ev, w_glob;
    logic [AW-1:0]      w_total2;
    logic [IW-1:0]      w_gslot;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_load      = (r_state == S_DONE) && (!o_valid || !i_stall);

    assign w_scan = (r_state == S_ASCAN) || (r_state == S_STAMP) ||
                    (r_state == S_GSCAN) || (r_state == S_PURGE);
    assign w_end  = (r_aidx == AW'(N)) && !r_pv;

    assign w_ev       = r_pv && r_valid[r_pidx];
    assign w_own      = (r_rd.owner == r_owner);
    assign w_keyhit   = w_ev && (r_rd.key == r_key);
    assign w_stamphit = w_ev && (r_rd.stamp == r_cand);

    assign w_own_ev = (r_own_cnt != '0) && (CW'(r_own_cnt) >= CW'(r_quota));
    assign w_total2 = r_total - AW'(w_own_ev);
    assign w_glob   = (w_total2 != '0) &&
                      ((CW'(w_total2) >= CW'(r_capacity)) || (w_total2 == AW'(N)));
    assign w_gslot  = r_has_oth ? r_slot_oth : (w_own_ev ? r_slot2 : r_slot1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_restart = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state   = (i_operation == OP_ADD) ? S_ASCAN : S_GSCAN;
                    w_restart = 1'b1;
                end
            end
            S_ASCAN: begin
                if (w_end) n_state = S_EVICT;
            end
            S_EVICT: begin
                n_state   = S_STAMP;
                w_restart = 1'b1;
            end
            S_STAMP: begin
                if (w_stamphit) begin
                    w_restart = 1'b1;
                end else if (w_end) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_GSCAN: begin
                if (w_keyhit) begin
                    n_state = S_GAGE;
                end else if (w_end) begin
                    n_state = S_DONE;
                end
            end
            S_GAGE: begin
                n_state = S_GCHK;
            end
            S_GCHK: begin
                if (r_age > r_max_age) begin
                    n_state   = S_PURGE;
                    w_restart = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PURGE: begin
                if (w_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
            r_quota    <= QUOTA_RST;
            r_max_age  <= MAX_AGE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CNT7_W-1:0];
                CFG_QUOTA:    r_quota    <= i_cfg_data[CNT7_W-1:0];
                CFG_MAX_AGE:  r_max_age  <= i_cfg_data[STAMP_W-1:0];
                default:      ;
            endcase
        end
    end

    // table RAM: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_free_found) begin
            r_mem[r_free] <= '{key: r_key, store: r_store, pos: r_pos,
                               owner: r_owner, stamp: r_cand};
        end
        r_rd <= r_mem[r_aidx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            case (r_state)
                S_EVICT: begin
                    if (w_own_ev)   r_valid[r_slot1] <= 1'b0;
                    if (w_glob)     r_valid[w_gslot] <= 1'b0;
                    if (r_match_ok) r_valid[r_match] <= 1'b0;
                end
                S_WRITE: begin
                    if (r_free_found) r_valid[r_free] <= 1'b1;
                end
                S_PURGE: begin
                    if (w_ev && (r_rd.stamp < r_limit)) r_valid[r_pidx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // scan address counter and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aidx <= '0;
            r_pv   <= 1'b0;
        end else if (w_restart) begin
            r_aidx <= '0;
            r_pv   <= 1'b0;
        end else if (w_scan && r_aidx != AW'(N)) begin
            r_aidx <= r_aidx + AW'(1);
            r_pv   <= 1'b1;
        end else begin
            r_pv <= 1'b0;
        end
        r_pidx <= r_aidx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_operation;
            r_key      <= i_cursor_key;
            r_store    <= i_store_id;
            r_pos      <= i_resume_position;
            r_owner    <= i_owner_session;
            r_now      <= i_now_ticks;
            r_cand     <= i_now_ticks;
            r_own_cnt  <= '0;
            r_total    <= '0;
            r_has1     <= 1'b0;
            r_has2     <= 1'b0;
            r_has_oth  <= 1'b0;
            r_match_ok <= 1'b0;
            r_status   <= (i_operation == OP_ADD) ? ST_ADDED : ST_NOTFOUND;
        end
        case (r_state)
            S_ASCAN: begin
                if (w_ev) begin
                    r_total <= r_total + AW'(1);
                    if (w_own) begin
                        r_own_cnt <= r_own_cnt + AW'(1);
                        if (!r_has1 || r_rd.stamp < r_min1) begin
                            r_has2  <= r_has1;
                            r_min2  <= r_min1;
                            r_slot2 <= r_slot1;
                            r_has1  <= 1'b1;
                            r_min1  <= r_rd.stamp;
                            r_slot1 <= r_pidx;
                        end else if (!r_has2 || r_rd.stamp < r_min2) begin
                            r_has2  <= 1'b1;
                            r_min2  <= r_rd.stamp;
                            r_slot2 <= r_pidx;
                        end
                    end else if (!r_has_oth || r_rd.stamp < r_min_oth) begin
                        r_has_oth  <= 1'b1;
                        r_min_oth  <= r_rd.stamp;
                        r_slot_oth <= r_pidx;
                    end
                    if (r_rd.key == r_key) begin
                        r_match_ok <= 1'b1;
                        r_match    <= r_pidx;
                    end
                end
            end
            S_EVICT: begin
                r_free_found <= 1'b0;
            end
            S_STAMP: begin
                if (w_stamphit) begin
                    r_cand       <= r_cand + STAMP_W'(1);
                    r_free_found <= 1'b0;
                end else if (r_pv && !r_valid[r_pidx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free       <= r_pidx;
                end
            end
            S_GSCAN: begin
                if (w_keyhit) begin
                    r_found  <= r_rd;
                    r_status <= ST_FOUND;
                end
            end
            S_GAGE: begin
                r_age   <= (r_found.stamp > r_now) ? '0 : r_now - r_found.stamp;
                r_limit <= r_now - r_max_age;
            end
            S_GCHK: begin
                if (r_age > r_max_age) r_status <= ST_EXPIRED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status <= r_status;
            if (r_status == ST_FOUND) begin
                o_found_store_id <= r_found.store;
                o_found_position <= r_found.pos;
                o_found_session  <= r_found.owner;
                o_found_stamp    <= r_found.stamp;
            end else begin
                o_found_store_id <= '0;
                o_found_position <= '0;
                o_found_session  <= '0;
                o_found_stamp    <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_write_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_free_found && !r_valid[r_free]))
        else $error("insert without a free slot");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_aidx <= AW'(N)))
        else $error("scan index out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer idle");

    a_add_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_op == OP_ADD) |-> (r_status == ST_ADDED))
        else $error("add reported a lookup status");
`endif

endmodule

`default_nettype wire

### sim/tb_cursor_table_quota_age_eviction.sv
// ----------------------------------------------------------------------------
// tb_cursor_table_quota_age_eviction
// Self-checking bench: directed and random add/get requests with random idling on both
// channels, predicted by an in-bench table model and compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cursor_table_quota_age_eviction;
    import cta_pkg::*;

    localparam int N        = 64;
    localparam int WD_LIMIT = 40000;
    localparam int HOLD_CYC = 300;

    typedef struct packed {
        logic [1:0]         status;
        logic [STORE_W-1:0] store;
        logic [POS_W-1:0]   pos;
        logic [OWNER_W-1:0] sess;
        logic [STAMP_W-1:0] stamp;
    } t_result;

    class cursor_scoreboard;
        bit                 vld [N];
        logic [KEY_W-1:0]   key [N];
        logic [STORE_W-1:0] store [N];
        logic [POS_W-1:0]   pos [N];
        logic [OWNER_W-1:0] owner [N];
        logic [STAMP_W-1:0] stamp [N];
        logic [6:0]         capacity;
        logic [6:0]         quota;
        logic [STAMP_W-1:0] max_age;
        t_result            pending_q[$];
        string              why;

        function void clear();
            foreach (vld[i]) vld[i] = 0;
            capacity = CAPACITY_RST;
            quota    = QUOTA_RST;
            max_age  = MAX_AGE_RST;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_CAPACITY: capacity = d[6:0];
                CFG_QUOTA:    quota    = d[6:0];
                CFG_MAX_AGE:  max_age  = d[STAMP_W-1:0];
                default: ;
            endcase
        endfunction

        // oldest valid slot; mode 0 any owner, 1 owner == o, 2 owner != o
        function int oldest(int mode, logic [OWNER_W-1:0] o);
            int b;
            b = -1;
            for (int i = 0; i < N; i++) begin
                if (!vld[i]) continue;
                if (mode == 1 && owner[i] != o) continue;
                if (mode == 2 && owner[i] == o) continue;
                if (b < 0 || stamp[i] < stamp[b]) b = i;
            end
            return b;
        endfunction

        function int find_key(logic [KEY_W-1:0] k);
            for (int i = 0; i < N; i++)
                if (vld[i] && key[i] == k) return i;
            return -1;
        endfunction

        function bit stamp_taken(logic [STAMP_W-1:0] s);
            for (int i = 0; i < N; i++)
                if (vld[i] && stamp[i] == s) return 1;
            return 0;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] k, logic [STORE_W-1:0] st,
                                   logic [POS_W-1:0] p, logic [OWNER_W-1:0] o,
                                   logic [STAMP_W-1:0] now);
            t_result            r;
            int                 own, total, v, slot, cap;
            logic [STAMP_W-1:0] s, age, lim;
            r = '0;
            if (op == OP_ADD) begin
                own = 0;
                total = 0;
                for (int i = 0; i < N; i++) begin
                    if (vld[i]) total++;
                    if (vld[i] && owner[i] == o) own++;
                end
                if (own > 0 && own >= quota) begin
                    v = oldest(1, o);
                    if (v >= 0) begin
                        vld[v] = 0;
                        total--;
                    end
                end
                cap = (capacity < N) ? capacity : N;
                if (total > 0 && total >= cap) begin
                    v = oldest(2, o);
                    if (v < 0) v = oldest(0, o);
                    if (v >= 0) vld[v] = 0;
                end
                v = find_key(k);
                if (v >= 0) vld[v] = 0;
                s = now;
                for (int j = 0; j <= N && stamp_taken(s); j++) s = s + 1'b1;
                slot = -1;
                for (int i = 0; i < N; i++)
                    if (!vld[i]) begin
                        slot = i;
                        break;
                    end
                if (slot >= 0) begin
                    vld[slot] = 1;
                    key[slot] = k;
                    store[slot] = st;
                    pos[slot] = p;
                    owner[slot] = o;
                    stamp[slot] = s;
                end
                r.status = ST_ADDED;
            end else begin
                v = find_key(k);
                if (v < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    age = (stamp[v] > now) ? '0 : now - stamp[v];
                    if (age > max_age) begin
                        lim = now - max_age;
                        for (int i = 0; i < N; i++)
                            if (vld[i] && stamp[i] < lim) vld[i] = 0;
                        r.status = ST_EXPIRED;
                    end else begin
                        r.status = ST_FOUND;
                        r.store  = store[v];
                        r.pos    = pos[v];
                        r.sess   = owner[v];
                        r.stamp  = stamp[v];
                    end
                end
            end
            pending_q.push_back(r);
        endfunction

        function bit check_result(t_result got);
            t_result e;
            if (pending_q.size() == 0) begin
                why = "result with no request outstanding";
                return 0;
            end
            e = pending_q.pop_front();
            why = "";
            if (got.status !== e.status)
                why = $sformatf("%s status got %0d exp %0d", why, got.status, e.status);
            if (got.store !== e.store)
                why = $sformatf("%s store got %h exp %h", why, got.store, e.store);
            if (got.pos !== e.pos)
                why = $sformatf("%s pos got %h exp %h", why, got.pos, e.pos);
            if (got.sess !== e.sess)
                why = $sformatf("%s session got %h exp %h", why, got.sess, e.sess);
            if (got.stamp !== e.stamp)
                why = $sformatf("%s stamp got %h exp %h", why, got.stamp, e.stamp);
            return why == "";
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_operation;
    logic [KEY_W-1:0]      i_cursor_key;
    logic [STORE_W-1:0]    i_store_id;
    logic [POS_W-1:0]      i_resume_position;
    logic [OWNER_W-1:0]    i_owner_session;
    logic [STAMP_W-1:0]    i_now_ticks;
    logic                  o_valid;
    logic                  i_stall;
    logic [1:0]            o_status;
    logic [STORE_W-1:0]    o_found_store_id;
    logic [POS_W-1:0]      o_found_position;
    logic [OWNER_W-1:0]    o_found_session;
    logic [STAMP_W-1:0]    o_found_stamp;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cursor_table_quota_age_eviction #(.TABLE_ENTRIES(N)) u_top (.*);

    cursor_scoreboard sb;
    int               n_errors;
    int               idle_cycles;
    bit               no_idle;
    bit               hold_req;
    logic [KEY_W-1:0]   key_pool [24];
    logic [OWNER_W-1:0] owner_pool [4];
    logic [STAMP_W-1:0] now;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic send_req(logic op, logic [KEY_W-1:0] k, logic [STORE_W-1:0] st,
                            logic [POS_W-1:0] p, logic [OWNER_W-1:0] o,
                            logic [STAMP_W-1:0] t);
        int gap;
        i_valid           <= 1'b1;
        i_operation       <= op;
        i_cursor_key      <= k;
        i_store_id        <= st;
        i_resume_position <= p;
        i_owner_session   <= o;
        i_now_ticks       <= t;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        sb.note_request(op, k, st, p, o, t);
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic random_req();
        logic               op;
        logic [KEY_W-1:0]   k;
        logic [OWNER_W-1:0] o;
        int                 r;
        op = 1'($urandom_range(0, 1));
        k  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 23)];
        o  = ($urandom_range(0, 9) == 0) ? $urandom : owner_pool[$urandom_range(0, 3)];
        r  = $urandom_range(0, 99);
        if (r >= 30 && r < 90) now = now + $urandom_range(1, 3);
        else if (r >= 90) now = now + $urandom_range(20, 100);
        send_req(op, k, 16'($urandom), {$urandom, $urandom}, o, now);
    endtask

    // result side
    initial begin
        t_result got;
        int      n;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge i_clk);
                n = 0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 5);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            got = {o_status, o_found_store_id, o_found_position, o_found_session,
                   o_found_stamp};
            if (!sb.check_result(got)) report(sb.why);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [6:0]         caps [7];
        logic [6:0]         quos [7];
        logic [STAMP_W-1:0] ages [7];
        logic [KEY_W-1:0]   ka;
        logic [OWNER_W-1:0] oa;
        caps = '{7'd64, 7'd4, 7'd0, 7'd127, 7'd8, 7'd1, 7'd64};
        quos = '{7'd16, 7'd2, 7'd0, 7'd1, 7'd3, 7'd64, 7'd64};
        ages = '{MAX_AGE_RST, 48'd30, 48'd0, '1, 48'd10, 48'd5, 48'd50};
        sb = new();
        sb.clear();
        n_errors = 0;
        idle_cycles = 0;
        no_idle = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_ADD;
        i_cursor_key = '0;
        i_store_id = '0;
        i_resume_position = '0;
        i_owner_session = '0;
        i_now_ticks = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAPACITY;
        i_cfg_data = '0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        foreach (owner_pool[i]) owner_pool[i] = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, replace, stamp bump, expiry, stamp wrap
        ka = key_pool[0];
        oa = owner_pool[0];
        send_req(OP_ADD, ka, '1, '1, oa, '0);
        send_req(OP_GET, ka, '0, '0, '0, '0);
        send_req(OP_GET, '1, '1, '1, '1, '0);
        send_req(OP_ADD, '0, '0, '0, '0, '0);
        send_req(OP_ADD, '1, 16'h1234, 64'h0123_4567_89ab_cdef, '1, '0);
        send_req(OP_ADD, ka, 16'h5a5a, 64'ha5a5_a5a5_a5a5_a5a5, oa, 48'd1);
        send_req(OP_GET, ka, '0, '0, '0, 48'd1);
        send_req(OP_GET, '0, '0, '0, '0, 48'd2);
        send_req(OP_GET, '1, '0, '0, '0, 48'd2);
        send_req(OP_GET, ka, '0, '0, '0, '1);
        send_req(OP_GET, '0, '0, '0, '0, '1);
        send_req(OP_ADD, key_pool[1], 16'd1, 64'd1, oa, '1);
        send_req(OP_ADD, key_pool[2], 16'd2, 64'd2, oa, '1);
        send_req(OP_ADD, key_pool[3], 16'd3, 64'd3, oa, '1);
        send_req(OP_GET, key_pool[1], '0, '0, '0, '1);
        send_req(OP_GET, key_pool[3], '0, '0, '0, '1);
        send_req(OP_GET, key_pool[2], '0, '0, '0, '1);
        drain();

        now = '0;
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(CFG_CAPACITY, {41'd0, caps[ph]});
            write_reg(CFG_QUOTA, {41'd0, quos[ph]});
            write_reg(CFG_MAX_AGE, ages[ph]);
            no_idle = (ph == 4);
            for (int i = 0; i < 64; i++) begin
                if (ph == 1 && i == 10) begin
                    hold_req = 1;
                    no_idle = 1;
                end
                if (ph == 1 && i == 40) no_idle = 0;
                if (ph == 3 && i == 32) drain();
                random_req();
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
